// ===== sv/aarm_pkg.sv =====
// aarm_pkg: shared constants and helpers for the axis-angle rotation matrix block
// depends on nothing; imported by aarm_cordic, aarm_matrix and the top level
`default_nettype none
package aarm_pkg;

    localparam int CORDIC_ITERS = 18;
    localparam int CORDIC_XW    = 33;
    localparam int CORDIC_ZW    = 26;
    localparam int AXIS_W       = 16;
    localparam int TRIG_W       = 17;
    localparam int ENTRY_W      = 17;
    localparam int SUM_W        = 50;

    localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [TRIG_W-1:0]    ONE_Q15     = 17'sd32768;

    typedef logic signed [CORDIC_ZW-1:0] t_zang;
    typedef logic signed [AXIS_W-1:0]    t_axis;
    typedef logic signed [TRIG_W-1:0]    t_trig;
    typedef logic signed [ENTRY_W-1:0]   t_entry;
    typedef logic signed [SUM_W-1:0]     t_sum;

    localparam t_zang ATAN_UNITS [0:CORDIC_ITERS-1] = '{
        26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050, 26'sd166669,
        26'sd83416, 26'sd41718, 26'sd20860, 26'sd10430, 26'sd5215,
        26'sd2608, 26'sd1304, 26'sd652, 26'sd326, 26'sd163,
        26'sd81, 26'sd41, 26'sd20
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // rounded sum (already offset by half) to saturated q2.15
    function automatic t_entry sat_entry(input t_sum v);
        t_sum sh;
        sh = v >>> 30;
        if (sh > 50'sd65535) begin
            sat_entry = 17'sd65535;
        end else if (sh < -50'sd65536) begin
            sat_entry = -17'sd65536;
        end else begin
            sat_entry = sh[ENTRY_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/axis_angle_rotation_matrix_top.sv =====
// axis_angle_rotation_matrix_top: axis and angle in, 3x3 rotation matrix out
// depends on aarm_pkg, aarm_cordic, aarm_matrix
//
//  channel   handshake                 payload
//  request   i_s_valid / o_s_ready     i_axis_x i_axis_y i_axis_z i_turn_angle
//  result    o_m_valid / i_m_ready     o_m00 .. o_m22
//
// one request per cycle unless the output stalls; the pipeline is 18 cordic iterations,
// a round and quadrant stage and four matrix stages
// synchronous active-low reset clears all stage valid bits; ready is low in reset
// one shared enable: the whole pipeline holds while the result register is full
// and not taken; bubbles flow and fill
`default_nettype none
module axis_angle_rotation_matrix_top
    import aarm_pkg::*;
#(
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    input  wire logic signed [15:0] i_axis_x,
    input  wire logic signed [15:0] i_axis_y,
    input  wire logic signed [15:0] i_axis_z,
    input  wire logic [15:0]       i_turn_angle,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    output logic signed [16:0]     o_m00,
    output logic signed [16:0]     o_m01,
    output logic signed [16:0]     o_m02,
    output logic signed [16:0]     o_m10,
    output logic signed [16:0]     o_m11,
    output logic signed [16:0]     o_m12,
    output logic signed [16:0]     o_m20,
    output logic signed [16:0]     o_m21,
    output logic signed [16:0]     o_m22
);
    logic  w_en;
    logic  w_cv;
    t_axis w_ax, w_ay, w_az;
    t_trig w_sin, w_cos;
    t_entry w_m [0:8];

    assign w_en      = !o_m_valid || i_m_ready;
    assign o_s_ready = w_en && i_rst_n;

    aarm_cordic #(
        .SINE_TABLE_ADDR_BITS(SINE_TABLE_ADDR_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_valid),
        .i_ax    (i_axis_x),
        .i_ay    (i_axis_y),
        .i_az    (i_axis_z),
        .i_angle (i_turn_angle),
        .o_vld   (w_cv),
        .o_ax    (w_ax),
        .o_ay    (w_ay),
        .o_az    (w_az),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    aarm_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_cv),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_az    (w_az),
        .i_sin   (w_sin),
        .i_cos   (w_cos),
        .o_vld   (o_m_valid),
        .o_m     (w_m)
    );

    assign o_m00 = w_m[0];
    assign o_m01 = w_m[1];
    assign o_m02 = w_m[2];
    assign o_m10 = w_m[3];
    assign o_m11 = w_m[4];
    assign o_m12 = w_m[5];
    assign o_m20 = w_m[6];
    assign o_m21 = w_m[7];
    assign o_m22 = w_m[8];
endmodule
`default_nettype wire

// ===== sv/aarm_cordic.sv =====
// aarm_cordic: pipelined rotation-mode cordic, one iteration per stage, plus rounding
// and quadrant stage; carries the axis alongside. depends on aarm_pkg
`default_nettype none
module aarm_cordic
    import aarm_pkg::*;
#(
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_axis i_ax,
    input  wire t_axis i_ay,
    input  wire t_axis i_az,
    input  wire logic [15:0] i_angle,
    output logic       o_vld,
    output t_axis      o_ax,
    output t_axis      o_ay,
    output t_axis      o_az,
    output t_trig      o_sin,
    output t_trig      o_cos
);
    localparam int DROP = 16 - SINE_TABLE_ADDR_BITS;

    logic [15:0] w_phase;
    assign w_phase = (i_angle >> DROP) << DROP;

    logic signed [CORDIC_XW-1:0] r_x [1:CORDIC_ITERS];
    logic signed [CORDIC_XW-1:0] r_y [1:CORDIC_ITERS];
    t_zang                       r_z [1:CORDIC_ITERS];
    t_axis                       r_ax [1:CORDIC_ITERS];
    t_axis                       r_ay [1:CORDIC_ITERS];
    t_axis                       r_az [1:CORDIC_ITERS];
    logic [1:0]                  r_q [1:CORDIC_ITERS];
    logic                        r_v [1:CORDIC_ITERS];

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_it
        logic signed [CORDIC_XW-1:0] w_x, w_y, n_x, n_y;
        t_zang w_z, n_z;
        t_axis w_ax, w_ay, w_az;
        logic [1:0] w_q;
        logic w_v;
        if (g == 0) begin : g_first
            assign w_x  = CORDIC_GAIN;
            assign w_y  = '0;
            assign w_z  = t_zang'({w_phase[13:0], 8'd0});
            assign w_ax = i_ax;
            assign w_ay = i_ay;
            assign w_az = i_az;
            assign w_q  = w_phase[15:14];
            assign w_v  = i_vld;
        end else begin : g_rest
            assign w_x  = r_x[g];
            assign w_y  = r_y[g];
            assign w_z  = r_z[g];
            assign w_ax = r_ax[g];
            assign w_ay = r_ay[g];
            assign w_az = r_az[g];
            assign w_q  = r_q[g];
            assign w_v  = r_v[g];
        end
        always_comb begin
            if (w_z >= 0) begin
                n_x = w_x - (w_y >>> g);
                n_y = w_y + (w_x >>> g);
                n_z = w_z - ATAN_UNITS[g];
            end else begin
                n_x = w_x + (w_y >>> g);
                n_y = w_y - (w_x >>> g);
                n_z = w_z + ATAN_UNITS[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= w_v;
            end
            if (i_en) begin
                r_x[g+1]  <= n_x;
                r_y[g+1]  <= n_y;
                r_z[g+1]  <= n_z;
                r_ax[g+1] <= w_ax;
                r_ay[g+1] <= w_ay;
                r_az[g+1] <= w_az;
                r_q[g+1]  <= w_q;
            end
        end
    end

    // round to q1.15, clamp to plus or minus one, then apply quadrant
    logic signed [CORDIC_XW-1:0] w_xr, w_yr;
    t_trig w_c, w_s, n_sin, n_cos;
    always_comb begin
        w_xr = (r_x[CORDIC_ITERS] + 33'sd16384) >>> 15;
        w_yr = (r_y[CORDIC_ITERS] + 33'sd16384) >>> 15;
        if (w_xr > 33'sd32768)       w_c = ONE_Q15;
        else if (w_xr < -33'sd32768) w_c = -ONE_Q15;
        else                         w_c = w_xr[TRIG_W-1:0];
        if (w_yr > 33'sd32768)       w_s = ONE_Q15;
        else if (w_yr < -33'sd32768) w_s = -ONE_Q15;
        else                         w_s = w_yr[TRIG_W-1:0];
        case (r_q[CORDIC_ITERS])
            QUAD_0: begin
                n_cos = w_c;
                n_sin = w_s;
            end
            QUAD_1: begin
                n_cos = -w_s;
                n_sin = w_c;
            end
            QUAD_2: begin
                n_cos = -w_c;
                n_sin = -w_s;
            end
            default: begin
                n_cos = w_s;
                n_sin = -w_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_v[CORDIC_ITERS];
        end
        if (i_en) begin
            o_sin <= n_sin;
            o_cos <= n_cos;
            o_ax  <= r_ax[CORDIC_ITERS];
            o_ay  <= r_ay[CORDIC_ITERS];
            o_az  <= r_az[CORDIC_ITERS];
        end
    end
endmodule
`default_nettype wire

// ===== sv/aarm_matrix.sv =====
// aarm_matrix: four-stage rodrigues matrix datapath (products, scale, sum, saturate)
// depends on aarm_pkg
`default_nettype none
module aarm_matrix
    import aarm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_axis i_ax,
    input  wire t_axis i_ay,
    input  wire t_axis i_az,
    input  wire t_trig i_sin,
    input  wire t_trig i_cos,
    output logic       o_vld,
    output t_entry     o_m [0:8]
);
    // stage a: axis products, axis times sine and one minus cosine
    logic signed [31:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    logic signed [32:0] r_qx, r_qy, r_qz;
    logic signed [17:0] r_omc;
    t_trig r_ca;
    logic r_va;

    // stage b: scaled by one minus cosine
    t_sum r_txx, r_tyy, r_tzz, r_txy, r_txz, r_tyz;
    logic signed [32:0] r_bqx, r_bqy, r_bqz;
    t_trig r_cb;
    logic r_vb;

    // stage c: sums with rounding offset
    t_sum r_v [0:8];
    logic r_vc;

    t_sum w_cc, w_sx, w_sy, w_sz, w_h;
    assign w_cc = t_sum'(r_cb) <<< 30;
    assign w_sx = t_sum'(r_bqx) <<< 15;
    assign w_sy = t_sum'(r_bqy) <<< 15;
    assign w_sz = t_sum'(r_bqz) <<< 15;
    assign w_h  = 50'sd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_vc  <= 1'b0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_va  <= i_vld;
            r_vb  <= r_va;
            r_vc  <= r_vb;
            o_vld <= r_vc;
        end
        if (i_en) begin
            r_pxx <= i_ax * i_ax;
            r_pyy <= i_ay * i_ay;
            r_pzz <= i_az * i_az;
            r_pxy <= i_ax * i_ay;
            r_pxz <= i_ax * i_az;
            r_pyz <= i_ay * i_az;
            r_qx  <= i_ax * i_sin;
            r_qy  <= i_ay * i_sin;
            r_qz  <= i_az * i_sin;
            r_omc <= 18'sd32768 - 18'(i_cos);
            r_ca  <= i_cos;

            r_txx <= r_pxx * r_omc;
            r_tyy <= r_pyy * r_omc;
            r_tzz <= r_pzz * r_omc;
            r_txy <= r_pxy * r_omc;
            r_txz <= r_pxz * r_omc;
            r_tyz <= r_pyz * r_omc;
            r_bqx <= r_qx;
            r_bqy <= r_qy;
            r_bqz <= r_qz;
            r_cb  <= r_ca;

            r_v[0] <= r_txx + w_cc + w_h;
            r_v[1] <= r_txy - w_sz + w_h;
            r_v[2] <= r_txz + w_sy + w_h;
            r_v[3] <= r_txy + w_sz + w_h;
            r_v[4] <= r_tyy + w_cc + w_h;
            r_v[5] <= r_tyz - w_sx + w_h;
            r_v[6] <= r_txz - w_sy + w_h;
            r_v[7] <= r_tyz + w_sx + w_h;
            r_v[8] <= r_tzz + w_cc + w_h;

            for (int k = 0; k < 9; k++) begin
                o_m[k] <= sat_entry(r_v[k]);
            end
        end
    end
endmodule
`default_nettype wire
